// File: hdl/sdce_pkg.sv
`default_nettype none

package sdce_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT,
        PH_PRE_FRAME,
        PH_PRE_SKIP,
        PH_PRE_RESP,
        PH_PRE_GAP,
        PH_FRAME,
        PH_SKIP,
        PH_RESP,
        PH_BUSY,
        PH_R2
    } t_phase;

    localparam logic       OP_START   = 1'b0;
    localparam logic       OP_BYTE    = 1'b1;

    localparam logic [7:0] C_IDLE_BYTE    = 8'hFF;
    localparam logic [7:0] C_CMD55_TOKEN  = 8'h77;
    localparam logic [7:0] C_CMD_PREFIX   = 8'h40;
    localparam logic [7:0] C_CMD_MASK     = 8'h7F;
    localparam logic [7:0] C_CRC_CMD0     = 8'h95;
    localparam logic [7:0] C_CRC_CMD8     = 8'h87;
    localparam logic [7:0] C_CRC_DEFAULT  = 8'hA5;
    localparam logic [7:0] C_LIMIT_RESET  = 8'd8;

    localparam logic [7:0] C_CMD_GO_IDLE  = 8'd0;
    localparam logic [7:0] C_CMD_IF_COND  = 8'd8;
    localparam logic [7:0] C_CMD_STOP     = 8'd12;
    localparam logic [7:0] C_CMD_STATUS   = 8'd13;
    localparam logic [7:0] C_CMD_ERASE    = 8'd38;
    localparam logic [7:0] C_ACMD_STATUS  = 8'h8D;

    localparam logic [2:0] C_FRAME_LAST   = 3'd5;

    typedef struct packed {
        logic        op;
        logic [7:0]  command_code;
        logic [31:0] argument;
        logic [7:0]  received_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]  send_byte;
        logic        exchange;
        logic        done_res;
        logic [15:0] response;
        logic        deselect;
    } t_result;

    function automatic logic [7:0] main_frame_byte(input logic [7:0] code,
                                                   input logic [31:0] arg,
                                                   input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = (C_CMD_PREFIX | code) & C_CMD_MASK;
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
                if (code == C_CMD_GO_IDLE) begin
                    b = C_CRC_CMD0;
                end else if (code == C_CMD_IF_COND) begin
                    b = C_CRC_CMD8;
                end else begin
                    b = C_CRC_DEFAULT;
                end
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] prefix_frame_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = C_CMD55_TOKEN;
            3'd1,
            3'd2,
            3'd3,
            3'd4:    b = 8'h00;
            default: b = C_CRC_DEFAULT;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sdce_if.sv
`default_nettype none

interface sdce_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  command_code;
    logic [31:0] argument;
    logic [7:0]  received_byte;

    modport source (output valid, output op, output command_code, output argument,
                    output received_byte, input ready);
    modport sink (input valid, input op, input command_code, input argument,
                  input received_byte, output ready);
endinterface

interface sdce_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  send_byte;
    logic        exchange;
    logic        done_res;
    logic [15:0] response;
    logic        deselect;

    modport source (output valid, output send_byte, output exchange, output done_res,
                    output response, output deselect, input ready);
    modport sink (input valid, input send_byte, input exchange, input done_res,
                  input response, input deselect, output ready);
endinterface

`default_nettype wire

// File: hdl/sdce_seq.sv
`default_nettype none

module sdce_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire sdce_pkg::t_item  i_item,
    input  wire logic [7:0]       i_limit,
    output sdce_pkg::t_result     o_result
);
    import sdce_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_poll, n_poll;
    logic [7:0]  r_code, n_code;
    logic [31:0] r_arg, n_arg;
    logic [15:0] r_resp, n_resp;

    logic [7:0]  w_code;
    logic [31:0] w_arg;
    logic [7:0]  w_rx;
    logic [7:0]  w_first;
    logic        w_poll_more;
    logic        w_need_busy;
    logic        w_need_r2;
    logic        w_start_waits;
    logic [2:0]  w_cnt_next;

    logic        w_active;
    logic        w_finish;
    logic        w_desel;
    logic [7:0]  w_byte;
    logic [15:0] w_fin_resp;

    // A start word uses its own code and argument in the same cycle.
    assign w_code = (i_item.op == OP_START) ? i_item.command_code : r_code;
    assign w_arg  = (i_item.op == OP_START) ? i_item.argument : r_arg;
    assign w_rx   = i_item.received_byte;

    assign w_first = w_code[7] ? prefix_frame_byte(3'd0)
                               : main_frame_byte(w_code, w_arg, 3'd0);
    assign w_poll_more   = w_rx[7] && (r_poll != 8'd0);
    assign w_need_busy   = (w_code == C_CMD_STOP) || (w_code == C_CMD_ERASE);
    assign w_need_r2     = (w_code == C_CMD_STATUS) || (w_code == C_ACMD_STATUS);
    assign w_start_waits = (w_code != C_CMD_GO_IDLE) && (w_code != C_CMD_STOP);
    assign w_cnt_next    = r_cnt + 3'd1;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_poll  = r_poll;
        n_code  = r_code;
        n_arg   = r_arg;
        n_resp  = r_resp;
        if (i_item.op == OP_START) begin
            n_code = i_item.command_code;
            n_arg  = i_item.argument;
            if (w_start_waits) begin
                n_phase = PH_WAIT;
            end else begin
                n_phase = w_code[7] ? PH_PRE_FRAME : PH_FRAME;
                n_cnt   = 3'd0;
            end
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    if (w_rx == C_IDLE_BYTE) begin
                        n_phase = w_code[7] ? PH_PRE_FRAME : PH_FRAME;
                        n_cnt   = 3'd0;
                    end
                end
                PH_PRE_FRAME: begin
                    if (r_cnt < C_FRAME_LAST) begin
                        n_cnt = w_cnt_next;
                    end else begin
                        n_phase = PH_PRE_SKIP;
                    end
                end
                PH_PRE_SKIP: begin
                    n_phase = PH_PRE_RESP;
                    n_poll  = i_limit;
                end
                PH_PRE_RESP: begin
                    if (w_poll_more) begin
                        n_poll = r_poll - 8'd1;
                    end else if (w_rx > 8'd1) begin
                        n_phase = PH_IDLE;
                        n_resp  = {w_rx, 8'h00};
                    end else begin
                        n_phase = PH_PRE_GAP;
                    end
                end
                PH_PRE_GAP: begin
                    n_phase = PH_FRAME;
                    n_cnt   = 3'd0;
                end
                PH_FRAME: begin
                    if (r_cnt < C_FRAME_LAST) begin
                        n_cnt = w_cnt_next;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_RESP;
                    n_poll  = i_limit;
                end
                PH_RESP: begin
                    if (w_poll_more) begin
                        n_poll = r_poll - 8'd1;
                    end else begin
                        n_resp = {w_rx, 8'h00};
                        if (w_need_busy) begin
                            n_phase = PH_BUSY;
                        end else if (w_need_r2) begin
                            n_phase = PH_R2;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_BUSY: begin
                    if (w_rx == C_IDLE_BYTE) begin
                        n_phase = w_need_r2 ? PH_R2 : PH_IDLE;
                    end
                end
                PH_R2: begin
                    n_phase = PH_IDLE;
                    n_resp  = {r_resp[15:8], r_resp[7:0] | w_rx};
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        w_active   = 1'b0;
        w_finish   = 1'b0;
        w_desel    = 1'b0;
        w_byte     = C_IDLE_BYTE;
        w_fin_resp = 16'h0000;
        if (i_item.op == OP_START) begin
            w_active = 1'b1;
            w_byte   = w_start_waits ? C_IDLE_BYTE : w_first;
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    w_active = 1'b1;
                    w_byte   = (w_rx == C_IDLE_BYTE) ? w_first : C_IDLE_BYTE;
                end
                PH_PRE_FRAME: begin
                    w_active = 1'b1;
                    if (r_cnt < C_FRAME_LAST) begin
                        w_byte = prefix_frame_byte(w_cnt_next);
                    end
                end
                PH_PRE_SKIP: begin
                    w_active = 1'b1;
                end
                PH_PRE_RESP: begin
                    // A failed CMD55 prefix ends the command and drops chip select.
                    if (!w_poll_more && (w_rx > 8'd1)) begin
                        w_finish   = 1'b1;
                        w_desel    = 1'b1;
                        w_fin_resp = {w_rx, 8'h00};
                    end else begin
                        w_active = 1'b1;
                    end
                end
                PH_PRE_GAP: begin
                    w_active = 1'b1;
                    w_byte   = main_frame_byte(w_code, w_arg, 3'd0);
                end
                PH_FRAME: begin
                    w_active = 1'b1;
                    if (r_cnt < C_FRAME_LAST) begin
                        w_byte = main_frame_byte(w_code, w_arg, w_cnt_next);
                    end
                end
                PH_SKIP: begin
                    w_active = 1'b1;
                end
                PH_RESP: begin
                    if (!w_poll_more && !w_need_busy && !w_need_r2) begin
                        w_finish   = 1'b1;
                        w_fin_resp = {w_rx, 8'h00};
                    end else begin
                        w_active = 1'b1;
                    end
                end
                PH_BUSY: begin
                    if ((w_rx == C_IDLE_BYTE) && !w_need_r2) begin
                        w_finish   = 1'b1;
                        w_fin_resp = r_resp;
                    end else begin
                        w_active = 1'b1;
                    end
                end
                PH_R2: begin
                    w_finish   = 1'b1;
                    w_fin_resp = {r_resp[15:8], r_resp[7:0] | w_rx};
                end
                default: begin
                    w_active = 1'b0;
                end
            endcase
        end
    end

    assign o_result.send_byte = w_active ? w_byte : C_IDLE_BYTE;
    assign o_result.exchange  = w_active;
    assign o_result.done_res  = w_finish;
    assign o_result.response  = w_finish ? w_fin_resp : 16'h0000;
    assign o_result.deselect  = w_desel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 3'd0;
            r_poll  <= 8'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_poll  <= n_poll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_code <= n_code;
            r_arg  <= n_arg;
            r_resp <= n_resp;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sd_spi_command_engine_core.sv
// Channel   Dir  Role                 Payload
// i_cmd     in   start or rx byte     op, command_code, argument, received_byte
// o_res     out  next exchange/result send_byte, exchange, done_res, response, deselect
// i_cfg_*   in   poll limit write     i_cfg_wdata (response_poll_limit)
//
// One word is taken per cycle while the result register is free or being taken; its
// result word passes from the input register through the sequencer into the result
// register, where it is held until it is taken.
// Reset (synchronous, active low) empties both registers, returns the sequencer to
// idle and loads the poll limit with 8. A stalled result holds the result register;
// the input register still takes one more word, then i_cmd.ready drops.
`default_nettype none

module sd_spi_command_engine_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sdce_in_if.sink    i_cmd,
    sdce_out_if.source o_res,
    input  wire logic  i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);
    import sdce_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic [7:0] r_limit;

    logic    w_advance;
    t_result w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_advance;

    sdce_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_item   (r_in),
        .i_limit  (r_limit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= C_LIMIT_RESET;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.op            <= i_cmd.op;
            r_in.command_code  <= i_cmd.command_code;
            r_in.argument      <= i_cmd.argument;
            r_in.received_byte <= i_cmd.received_byte;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.send_byte = r_out.send_byte;
    assign o_res.exchange  = r_out.exchange;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.response  = r_out.response;
    assign o_res.deselect  = r_out.deselect;

    a_done_no_exchange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.exchange)
        else $error("finished command still asks for an exchange");

    a_read_only_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.exchange |-> o_res.send_byte == C_IDLE_BYTE)
        else $error("send byte not 0xFF without an exchange");

    a_deselect_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.deselect |-> o_res.done_res)
        else $error("deselect without a finished command");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("input register lost a word while stalled");

endmodule

`default_nettype wire
